// ----- design/prq_pkg.sv -----
`default_nettype none
package prq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ID_BITS     = 8;
  localparam int unsigned PRIO_BITS   = 8;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRY_W     = ID_BITS + PRIO_BITS;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PTR_HOLD = 3'd0,
    PTR_ZERO = 3'd1,
    PTR_TAIL = 3'd2,
    PTR_INC  = 3'd3,
    PTR_DEC  = 3'd4
  } ptr_op_e;

  typedef enum logic [1:0] {
    WA_PTR     = 2'd0,
    WA_PTR_INC = 2'd1,
    WA_PTR_DEC = 2'd2
  } wa_sel_e;

  typedef enum logic {
    WD_ITEM  = 1'b0,
    WD_RDATA = 1'b1
  } wd_sel_e;

  typedef enum logic [1:0] {
    FILL_HOLD = 2'd0,
    FILL_INC  = 2'd1,
    FILL_DEC  = 2'd2
  } fill_op_e;

  typedef enum logic [2:0] {
    RES_HOLD  = 3'd0,
    RES_OK    = 3'd1,
    RES_FULL  = 3'd2,
    RES_EMPTY = 3'd3,
    RES_HEAD  = 3'd4
  } res_op_e;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    ptr_op_e  ptr_op;
    logic     wr_en;
    wa_sel_e  wa_sel;
    wd_sel_e  wd_sel;
    fill_op_e fill_op;
    res_op_e  res_op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic fill_one;
    logic ptr_zero;
    logic ptr_last;
    logic prio_lt;
  } sts_t;

endpackage
`default_nettype wire

// ----- design/prq_ram.sv -----
`default_nettype none
module prq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- design/prq_datapath.sv -----
`default_nettype none
module prq_datapath
  import prq_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  input  wire logic [ID_BITS-1:0]   in_id_i,
  input  wire logic [PRIO_BITS-1:0] in_prio_i,
  output logic      [ID_BITS-1:0]   out_id_o,
  output logic      [PRIO_BITS-1:0] out_prio_o,
  output status_e                   out_status_o,
  output logic      [CNT_W-1:0]     occupancy_o
);

  logic [ID_BITS-1:0]   id_q;
  logic [PRIO_BITS-1:0] prio_q;
  logic [PTR_W-1:0]     ptr_q, ptr_d;
  logic [CNT_W-1:0]     fill_q, fill_d;
  logic [ID_BITS-1:0]   res_id_q;
  logic [PRIO_BITS-1:0] res_prio_q;
  status_e              res_st_q;
  logic [PTR_W-1:0]     wr_addr;
  logic [ENTRY_W-1:0]   wr_data;
  logic [ENTRY_W-1:0]   rdata;
  logic [PRIO_BITS-1:0] rd_prio;
  logic [ID_BITS-1:0]   rd_id;

  assign rd_prio = rdata[ENTRY_W-1:ID_BITS];
  assign rd_id   = rdata[ID_BITS-1:0];

  always_comb begin
    unique case (cmd_i.ptr_op)
      PTR_ZERO: ptr_d = '0;
      PTR_TAIL: ptr_d = PTR_W'(fill_q - CNT_W'(1));
      PTR_INC:  ptr_d = ptr_q + PTR_W'(1);
      PTR_DEC:  ptr_d = ptr_q - PTR_W'(1);
      default:  ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.fill_op)
      FILL_INC: fill_d = fill_q + CNT_W'(1);
      FILL_DEC: fill_d = fill_q - CNT_W'(1);
      default:  fill_d = fill_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wa_sel)
      WA_PTR_INC: wr_addr = ptr_q + PTR_W'(1);
      WA_PTR_DEC: wr_addr = ptr_q - PTR_W'(1);
      default:    wr_addr = ptr_q;
    endcase
  end

  assign wr_data = (cmd_i.wd_sel == WD_RDATA) ? rdata : {prio_q, id_q};

  prq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (cmd_i.rd_en),
    .raddr_i(ptr_d),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
    end else begin
      ptr_q  <= ptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q   <= in_id_i;
      prio_q <= in_prio_i;
    end
    unique case (cmd_i.res_op)
      RES_OK: begin
        res_id_q   <= '0;
        res_prio_q <= '0;
        res_st_q   <= ST_OK;
      end
      RES_FULL: begin
        res_id_q   <= '0;
        res_prio_q <= '0;
        res_st_q   <= ST_FULL;
      end
      RES_EMPTY: begin
        res_id_q   <= '0;
        res_prio_q <= '0;
        res_st_q   <= ST_EMPTY;
      end
      RES_HEAD: begin
        res_id_q   <= rd_id;
        res_prio_q <= rd_prio;
        res_st_q   <= ST_OK;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.full     = (fill_q == CNT_W'(QUEUE_DEPTH));
  assign sts_o.empty    = (fill_q == '0);
  assign sts_o.fill_one = (fill_q == CNT_W'(1));
  assign sts_o.ptr_zero = (ptr_q == '0);
  assign sts_o.ptr_last = ((CNT_W'(ptr_q) + CNT_W'(1)) == fill_q);
  assign sts_o.prio_lt  = (rd_prio < prio_q);

  assign out_id_o     = res_id_q;
  assign out_prio_o   = res_prio_q;
  assign out_status_o = res_st_q;
  assign occupancy_o  = fill_q;

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy exceeds the queue depth");
  a_no_grow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_op == FILL_INC |-> fill_q < CNT_W'(QUEUE_DEPTH))
    else $error("entry added to a full queue");
  a_no_shrink_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_op == FILL_DEC |-> fill_q != '0)
    else $error("entry removed from an empty queue");
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> CNT_W'(wr_addr) <= fill_q)
    else $error("write beyond the stored entries");
`endif

endmodule
`default_nettype wire

// ----- design/prq_ctrl.sv -----
`default_nettype none
module prq_ctrl
  import prq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_valid_i,
  input  wire logic s_kind_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  wire logic m_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_ENQ_CMP   = 6'b000010,
    S_ENQ_PUT   = 6'b000100,
    S_DEQ_HEAD  = 6'b001000,
    S_DEQ_SHIFT = 6'b010000,
    S_RESP      = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.ptr_op  = PTR_HOLD;
    cmd_o.wa_sel  = WA_PTR;
    cmd_o.wd_sel  = WD_ITEM;
    cmd_o.fill_op = FILL_HOLD;
    cmd_o.res_op  = RES_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          if (s_kind_i == KIND_ENQ) begin
            if (sts_i.full) begin
              cmd_o.res_op = RES_FULL;
              state_d      = S_RESP;
            end else if (sts_i.empty) begin
              cmd_o.ptr_op = PTR_ZERO;
              state_d      = S_ENQ_PUT;
            end else begin
              cmd_o.ptr_op = PTR_TAIL;
              cmd_o.rd_en  = 1'b1;
              state_d      = S_ENQ_CMP;
            end
          end else begin
            if (sts_i.empty) begin
              cmd_o.res_op = RES_EMPTY;
              state_d      = S_RESP;
            end else begin
              cmd_o.ptr_op = PTR_ZERO;
              cmd_o.rd_en  = 1'b1;
              state_d      = S_DEQ_HEAD;
            end
          end
        end
      end
      S_ENQ_CMP: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = WA_PTR_INC;
        if (sts_i.prio_lt) begin
          cmd_o.wd_sel = WD_RDATA;
          if (sts_i.ptr_zero) begin
            state_d = S_ENQ_PUT;
          end else begin
            cmd_o.ptr_op = PTR_DEC;
            cmd_o.rd_en  = 1'b1;
          end
        end else begin
          cmd_o.fill_op = FILL_INC;
          cmd_o.res_op  = RES_OK;
          state_d       = S_RESP;
        end
      end
      S_ENQ_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.fill_op = FILL_INC;
        cmd_o.res_op  = RES_OK;
        state_d       = S_RESP;
      end
      S_DEQ_HEAD: begin
        cmd_o.res_op = RES_HEAD;
        if (sts_i.fill_one) begin
          cmd_o.fill_op = FILL_DEC;
          state_d       = S_RESP;
        end else begin
          cmd_o.ptr_op = PTR_INC;
          cmd_o.rd_en  = 1'b1;
          state_d      = S_DEQ_SHIFT;
        end
      end
      S_DEQ_SHIFT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = WA_PTR_DEC;
        cmd_o.wd_sel = WD_RDATA;
        if (sts_i.ptr_last) begin
          cmd_o.fill_op = FILL_DEC;
          state_d       = S_RESP;
        end else begin
          cmd_o.ptr_op = PTR_INC;
          cmd_o.rd_en  = 1'b1;
        end
      end
      S_RESP: begin
        if (m_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = (state_q == S_RESP);

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_ready_o && m_valid_o))
    else $error("request accepted while a result is pending");
  a_result_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && m_ready_i |=> s_ready_o)
    else $error("queue did not return to idle after a result");
  a_shift_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DEQ_SHIFT |-> cmd_o.wr_en && cmd_o.wd_sel == WD_RDATA)
    else $error("dequeue shift step without a move");
`endif

endmodule
`default_nettype wire

// ----- design/priority_ready_queue_top.sv -----
`default_nettype none
// Ready queue of up to sixteen process entries kept sorted by priority, highest
// first, with equal priorities served in arrival order. Each request is an enqueue
// or a dequeue and returns exactly one result with status and the occupancy after
// it. Requests are handled one at a time through a single RAM with one write and
// one registered read port: an enqueue walks from the tail, moving one entry per
// cycle past each entry of lower priority; a dequeue moves every remaining entry
// one place toward the head. A full enqueue or empty dequeue goes straight to its
// result. The result is held until taken, and the next request is accepted in the
// cycle after.
module priority_ready_queue_top
  import prq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // proc_id [7:0], prio [15:8]
  input  wire logic [15:0] s_axis_tdata_i,
  // kind [0]
  input  wire logic [0:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // out_proc_id [7:0], out_prio [15:8], status [17:16], occupancy [22:18], zero [23]
  output logic [23:0]      m_axis_tdata_o
);

  cmd_t                 cmd;
  sts_t                 sts;
  logic [ID_BITS-1:0]   out_id;
  logic [PRIO_BITS-1:0] out_prio;
  status_e              out_status;
  logic [CNT_W-1:0]     occupancy;

  prq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid_i),
    .s_kind_i (s_axis_tuser_i[0]),
    .s_ready_o(s_axis_tready_o),
    .m_valid_o(m_axis_tvalid_o),
    .m_ready_i(m_axis_tready_i),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  prq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_id_i     (s_axis_tdata_i[7:0]),
    .in_prio_i   (s_axis_tdata_i[15:8]),
    .out_id_o    (out_id),
    .out_prio_o  (out_prio),
    .out_status_o(out_status),
    .occupancy_o (occupancy)
  );

  assign m_axis_tdata_o = {1'b0, occupancy, out_status, out_prio, out_id};

endmodule
`default_nettype wire
